FILE: hw/rtl/best_fit_slot_pool_allocator_assert.svh
// Assertion macros used by the slot pool allocator RTL.
`ifndef BEST_FIT_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/bfsp_pkg.sv
// Types and constants of the best-fit slot pool allocator.
package bfsp_pkg;

    localparam int SLOT_W   = 6;
    localparam int TOKEN_W  = 16;
    localparam int EMB_W    = 13;
    localparam int GEN_W    = 32;
    localparam int FREE_W   = 7;

    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_CHECK   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD       = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_NOT_OWNER = 2'd3
    } status_t;

    // Request fields broadcast to every cell during a scan.
    typedef struct packed {
        logic [TOKEN_W-1:0] tokens;
        logic [EMB_W-1:0]   width;
        logic [SLOT_W-1:0]  hslot;
        logic [GEN_W-1:0]   hgen;
    } req_t;

    // Partial scan result handed from cell to cell.
    typedef struct packed {
        logic               best_vld;
        logic [SLOT_W-1:0]  best_idx;
        logic [TOKEN_W-1:0] best_cap;
        logic [GEN_W-1:0]   best_gen;
        logic               free_vld;
        logic [SLOT_W-1:0]  free_idx;
        logic [GEN_W-1:0]   free_gen;
        logic [FREE_W-1:0]  free_cnt;
        logic               match;
    } token_t;

    // State update broadcast to the cells when an item finishes.
    typedef struct packed {
        logic               grant_en;
        logic               reback;
        logic               release_en;
        logic [SLOT_W-1:0]  idx;
        logic [GEN_W-1:0]   new_gen;
        logic [TOKEN_W-1:0] tokens;
        logic [EMB_W-1:0]   width;
    } commit_t;

    localparam token_t TOKEN_INIT = '0;

endpackage

FILE: hw/rtl/bfsp_cell.sv
// One slot of the pool: slot state plus one stage of the scan chain.
module bfsp_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bfsp_pkg::req_t   req,
    input  bfsp_pkg::token_t tok_in,
    input  bfsp_pkg::commit_t commit,
    output bfsp_pkg::token_t tok_out
);

    localparam logic [bfsp_pkg::SLOT_W-1:0] IdxCode = bfsp_pkg::SLOT_W'(IDX);

    logic                          backed_reg;
    logic [bfsp_pkg::TOKEN_W-1:0]  cap_reg;
    logic [bfsp_pkg::EMB_W-1:0]    wid_reg;
    logic [bfsp_pkg::GEN_W-1:0]    gen_reg;
    logic [bfsp_pkg::TOKEN_W-1:0]  own_reg;
    logic                          busy_reg;
    bfsp_pkg::token_t              tok_reg;
    bfsp_pkg::token_t              tok_next;
    logic                          fits;
    logic                          here;

    assign here = (commit.idx == IdxCode);

    // Best fit: free, backed, same width, enough room, strictly smaller than so far.
    assign fits = !busy_reg && backed_reg && (wid_reg == req.width) &&
                  (cap_reg >= req.tokens) &&
                  (!tok_in.best_vld || (cap_reg < tok_in.best_cap));

    always_comb
    begin
        tok_next = tok_in;
        if (fits)
        begin
            tok_next.best_vld = 1'b1;
            tok_next.best_idx = IdxCode;
            tok_next.best_cap = cap_reg;
            tok_next.best_gen = gen_reg;
        end
        if (!tok_in.free_vld && !busy_reg)
        begin
            tok_next.free_vld = 1'b1;
            tok_next.free_idx = IdxCode;
            tok_next.free_gen = gen_reg;
        end
        tok_next.free_cnt = tok_in.free_cnt +
                            {{(bfsp_pkg::FREE_W-1){1'b0}}, ~busy_reg};
        tok_next.match = tok_in.match ||
                         ((req.hslot == IdxCode) && busy_reg && (gen_reg == req.hgen) &&
                          (own_reg == req.tokens) && (wid_reg == req.width));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backed_reg <= 1'b0;
            cap_reg    <= '0;
            wid_reg    <= '0;
            gen_reg    <= '0;
            own_reg    <= '0;
            busy_reg   <= 1'b0;
            tok_reg    <= bfsp_pkg::TOKEN_INIT;
        end
        else
        begin
            tok_reg <= tok_next;
            if (commit.grant_en && here)
            begin
                gen_reg  <= commit.new_gen;
                own_reg  <= commit.tokens;
                busy_reg <= 1'b1;
                if (commit.reback)
                begin
                    backed_reg <= 1'b1;
                    cap_reg    <= commit.tokens;
                    wid_reg    <= commit.width;
                end
            end
            else if (commit.release_en && here)
            begin
                busy_reg <= 1'b0;
                own_reg  <= '0;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/best_fit_slot_pool_allocator.sv
// Top level of the best-fit slot pool allocator.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request item: acquire,
//   release or check of a slot handle. Output channel (out_valid/out_ready)
//   returns exactly one result item per request: status, granted slot and
//   generation, a re-backing flag and the number of free slots afterwards.
//   cfg_wr_en/cfg_wr_data write pool_enabled; write it only while idle.
// Timing:
//   Each slot lives in one cell of a chain. A request is latched, then a scan
//   record walks the chain one cell per cycle, then the commit state updates
//   the chosen cell and loads the result register once that register is free.
//   A new item is taken only after the previous one has committed, so items
//   never overlap in the chain.
// Reset:
//   All slots become unbacked, free, generation 0; pool_enabled becomes 1.
// Stall:
//   A waiting result sits in the output register while the next item is
//   accepted and scanned; its commit waits until that register is free.
`include "best_fit_slot_pool_allocator_assert.svh"

module best_fit_slot_pool_allocator #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [bfsp_pkg::TOKEN_W-1:0]  num_tokens,
    input  logic [bfsp_pkg::EMB_W-1:0]    embedding_width,
    input  logic [bfsp_pkg::SLOT_W-1:0]   handle_slot,
    input  logic [bfsp_pkg::GEN_W-1:0]    handle_generation,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [bfsp_pkg::SLOT_W-1:0]   granted_slot,
    output logic [bfsp_pkg::GEN_W-1:0]    granted_generation,
    output logic                          rebacked,
    output logic [bfsp_pkg::FREE_W-1:0]   free_slots
);

    localparam int CntW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [CntW-1:0] LastCnt = CntW'(SLOT_COUNT - 1);
    localparam logic [bfsp_pkg::FREE_W-1:0] SlotTotal = bfsp_pkg::FREE_W'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [CntW-1:0]       cnt_reg;
    logic [CntW-1:0]       cnt_next;
    logic                  pool_enabled_reg;

    bfsp_pkg::func_t       func_reg;
    bfsp_pkg::req_t        req_reg;

    bfsp_pkg::token_t      chain_tok [SLOT_COUNT+1];
    bfsp_pkg::token_t      tail;
    bfsp_pkg::commit_t     commit;

    logic                  in_fire;
    logic                  out_load;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    bfsp_pkg::status_t     res_status;
    logic [bfsp_pkg::SLOT_W-1:0] res_slot;
    logic [bfsp_pkg::GEN_W-1:0]  sel_gen;
    logic [bfsp_pkg::GEN_W-1:0]  inc_gen;
    logic [bfsp_pkg::GEN_W-1:0]  res_gen;
    logic                  res_reb;
    logic                  res_grant;
    logic                  res_release;
    logic [bfsp_pkg::FREE_W-1:0] res_free;

    bfsp_pkg::status_t     status_reg;
    logic [bfsp_pkg::SLOT_W-1:0] slot_reg;
    logic [bfsp_pkg::GEN_W-1:0]  gen_reg;
    logic                  reb_reg;
    logic [bfsp_pkg::FREE_W-1:0] free_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    // Scan chain: cell 0 starts from an empty record, the last cell holds the answer.
    assign chain_tok[0] = bfsp_pkg::TOKEN_INIT;

    for (genvar gi = 0; gi < SLOT_COUNT; gi++)
    begin : g_cell
        bfsp_cell #(
            .IDX (gi)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req     (req_reg),
            .tok_in  (chain_tok[gi]),
            .commit  (commit),
            .tok_out (chain_tok[gi+1])
        );
    end

    assign tail = chain_tok[SLOT_COUNT];

    // Decide the outcome from the finished scan record.
    always_comb
    begin
        res_status  = bfsp_pkg::ST_BAD;
        res_slot    = '0;
        sel_gen     = '0;
        res_reb     = 1'b0;
        res_grant   = 1'b0;
        res_release = 1'b0;
        unique case (func_reg)
            bfsp_pkg::FUNC_ACQUIRE:
            begin
                if (pool_enabled_reg && (req_reg.tokens != '0) && (req_reg.width != '0))
                begin
                    priority if (tail.best_vld)
                    begin
                        res_status = bfsp_pkg::ST_OK;
                        res_grant  = 1'b1;
                        res_slot   = tail.best_idx;
                        sel_gen    = tail.best_gen;
                    end
                    else if (tail.free_vld)
                    begin
                        res_status = bfsp_pkg::ST_OK;
                        res_grant  = 1'b1;
                        res_reb    = 1'b1;
                        res_slot   = tail.free_idx;
                        sel_gen    = tail.free_gen;
                    end
                    else
                    begin
                        res_status = bfsp_pkg::ST_NO_FREE;
                    end
                end
            end
            bfsp_pkg::FUNC_RELEASE,
            bfsp_pkg::FUNC_CHECK:
            begin
                if (({1'b0, req_reg.hslot} < SlotTotal) && (req_reg.hgen != '0))
                begin
                    if (tail.match)
                    begin
                        res_status  = bfsp_pkg::ST_OK;
                        res_release = (func_reg == bfsp_pkg::FUNC_RELEASE);
                    end
                    else
                    begin
                        res_status = bfsp_pkg::ST_NOT_OWNER;
                    end
                end
            end
            default:
            begin
                res_status = bfsp_pkg::ST_BAD;
            end
        endcase
    end

    // Bump generation, skip zero on wrap.
    assign inc_gen = sel_gen + bfsp_pkg::GEN_W'(1);
    assign res_gen = !res_grant ? '0 :
                     (inc_gen == '0) ? bfsp_pkg::GEN_W'(1) : inc_gen;

    assign res_free = tail.free_cnt
                    - {{(bfsp_pkg::FREE_W-1){1'b0}}, res_grant}
                    + {{(bfsp_pkg::FREE_W-1){1'b0}}, res_release};

    always_comb
    begin
        commit            = '0;
        commit.grant_en   = out_load && res_grant;
        commit.reback     = res_reb;
        commit.release_en = out_load && res_release;
        commit.idx        = res_grant ? res_slot : req_reg.hslot;
        commit.new_gen    = res_gen;
        commit.tokens     = req_reg.tokens;
        commit.width      = req_reg.width;
    end

    // Sequencer: latch, walk the chain, commit.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LastCnt)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CntW'(1);
                end
            end
            S_COMMIT:
            begin
                if (out_load)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            pool_enabled_reg <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pool_enabled_reg <= cfg_wr_data;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg       <= bfsp_pkg::func_t'(func);
            req_reg.tokens <= num_tokens;
            req_reg.width  <= embedding_width;
            req_reg.hslot  <= handle_slot;
            req_reg.hgen   <= handle_generation;
        end
        if (out_load)
        begin
            status_reg <= res_status;
            slot_reg   <= res_slot;
            gen_reg    <= res_gen;
            reb_reg    <= res_reb;
            free_reg   <= res_free;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign granted_slot       = slot_reg;
    assign granted_generation = gen_reg;
    assign rebacked           = reb_reg;
    assign free_slots         = free_reg;

    `BFSP_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_fire, state_reg == S_SCAN)
    `BFSP_ASSERT_IMPL(a_result_from_commit, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_COMMIT))
    `BFSP_ASSERT_IMPL(a_free_in_range, clk, rst_n, out_valid_reg, free_reg <= SlotTotal)
    `BFSP_ASSERT_IMPL(a_reback_grants, clk, rst_n, out_valid_reg && reb_reg, (status_reg == bfsp_pkg::ST_OK) && (gen_reg != '0))

endmodule

FILE: test/best_fit_slot_pool_allocator_test.sv
// Self-checking testbench for the best-fit slot pool allocator.
module best_fit_slot_pool_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_W    = bfsp_pkg::TOKEN_W;
    localparam int EMB_W      = bfsp_pkg::EMB_W;
    localparam int SLOT_W     = bfsp_pkg::SLOT_W;
    localparam int GEN_W      = bfsp_pkg::GEN_W;
    localparam int FREE_W     = bfsp_pkg::FREE_W;

    localparam int SLOTS      = 8;
    localparam int CLK_HALF   = 6;
    localparam int IDLE_LIMIT = 2000;
    // Scan of the cell chain plus commit, with some margin.
    localparam int SETTLE     = SLOTS + 4;

    // func value the package leaves unnamed; the block must reject it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // How a handle built from the live pool state gets spoiled.
    typedef enum logic [1:0] {
        TAMPER_NONE   = 2'd0,
        TAMPER_GEN    = 2'd1,
        TAMPER_TOKENS = 2'd2,
        TAMPER_WIDTH  = 2'd3
    } tamper_e;

    // One request item. When "bound" is set, tokens, width and generation are
    // taken from slot hslot of the predicted pool when the item is offered.
    typedef struct packed {
        logic [1:0]         code;
        logic [TOKEN_W-1:0] tokens;
        logic [EMB_W-1:0]   width;
        logic [SLOT_W-1:0]  hslot;
        logic [GEN_W-1:0]   hgen;
        logic               bound;
        tamper_e            tamper;
    } req_s;

    typedef struct packed {
        bfsp_pkg::status_t  status;
        logic [SLOT_W-1:0]  slot;
        logic [GEN_W-1:0]   gen;
        logic               rebacked;
        logic [FREE_W-1:0]  free;
    } result_s;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b1;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          func = bfsp_pkg::FUNC_ACQUIRE;
    logic [TOKEN_W-1:0]  num_tokens = '0;
    logic [EMB_W-1:0]    embedding_width = '0;
    logic [SLOT_W-1:0]   handle_slot = '0;
    logic [GEN_W-1:0]    handle_generation = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [GEN_W-1:0]    granted_generation;
    logic                rebacked;
    logic [FREE_W-1:0]   free_slots;

    best_fit_slot_pool_allocator #(
        .SLOT_COUNT(SLOTS)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .func              (func),
        .num_tokens        (num_tokens),
        .embedding_width   (embedding_width),
        .handle_slot       (handle_slot),
        .handle_generation (handle_generation),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .granted_slot      (granted_slot),
        .granted_generation(granted_generation),
        .rebacked          (rebacked),
        .free_slots        (free_slots)
    );

    always #CLK_HALF clk = ~clk;

    // Predicted pool: one entry per slot, plus the enable register.
    bit                  pool_on = 1'b1;
    logic                slot_backed [SLOTS];
    logic [TOKEN_W-1:0]  slot_cap    [SLOTS];
    logic [EMB_W-1:0]    slot_width  [SLOTS];
    logic [GEN_W-1:0]    slot_gen    [SLOTS];
    logic [TOKEN_W-1:0]  slot_owner  [SLOTS];
    logic                slot_busy   [SLOTS];

    req_s    request_queue[$];
    result_s due_results[$];
    req_s    offered;
    bit      steady = 1'b0;
    int      failures = 0;
    int      idle_cycles = 0;
    int      items_taken = 0;
    int      n_grants = 0;
    int      n_rebacks = 0;
    int      n_full = 0;
    int      n_not_owner = 0;
    int      n_rejected = 0;

    task automatic report_error(input string msg);
        failures++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Apply one request to the predicted pool and return the result it gives.
    function automatic result_s pool_step(input req_s r);
        result_s res;
        int      pick;
        int      n_free;
        res = '0;
        res.status = bfsp_pkg::ST_BAD;
        pick = -1;
        n_free = 0;
        if (r.code == bfsp_pkg::FUNC_ACQUIRE) begin
            if (pool_on && r.tokens != 0 && r.width != 0) begin
                // Best fit: smallest sufficient capacity of the same width,
                // lowest index on ties (strict less-than keeps the first).
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_busy[i] && slot_backed[i] && slot_width[i] == r.width &&
                        slot_cap[i] >= r.tokens &&
                        (pick < 0 || slot_cap[i] < slot_cap[pick]))
                        pick = i;
                // No fit: reshape the first free slot to the exact request.
                if (pick < 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (pick < 0 && !slot_busy[i])
                            pick = i;
                    if (pick >= 0) begin
                        slot_backed[pick] = 1'b1;
                        slot_cap[pick]    = r.tokens;
                        slot_width[pick]  = r.width;
                        res.rebacked      = 1'b1;
                    end
                end
                if (pick < 0) begin
                    res.status = bfsp_pkg::ST_NO_FREE;
                end
                else begin
                    // Generation skips zero on wrap so no live handle is zero.
                    slot_gen[pick] = slot_gen[pick] + 1'b1;
                    if (slot_gen[pick] == 0)
                        slot_gen[pick] = 1;
                    slot_owner[pick] = r.tokens;
                    slot_busy[pick]  = 1'b1;
                    res.status = bfsp_pkg::ST_OK;
                    res.slot   = pick[SLOT_W-1:0];
                    res.gen    = slot_gen[pick];
                end
            end
        end
        else if (r.code == bfsp_pkg::FUNC_RELEASE || r.code == bfsp_pkg::FUNC_CHECK) begin
            if (r.hslot < SLOTS && r.hgen != 0) begin
                if (slot_busy[r.hslot] && slot_gen[r.hslot] == r.hgen &&
                    slot_owner[r.hslot] == r.tokens && slot_width[r.hslot] == r.width) begin
                    res.status = bfsp_pkg::ST_OK;
                    if (r.code == bfsp_pkg::FUNC_RELEASE) begin
                        slot_busy[r.hslot]  = 1'b0;
                        slot_owner[r.hslot] = '0;
                    end
                end
                else begin
                    res.status = bfsp_pkg::ST_NOT_OWNER;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (!slot_busy[i])
                n_free++;
        res.free = n_free[FREE_W-1:0];
        case (res.status)
            bfsp_pkg::ST_OK:        if (r.code == bfsp_pkg::FUNC_ACQUIRE) n_grants++;
            bfsp_pkg::ST_NO_FREE:   n_full++;
            bfsp_pkg::ST_NOT_OWNER: n_not_owner++;
            default:                n_rejected++;
        endcase
        if (res.rebacked)
            n_rebacks++;
        return res;
    endfunction

    // Driver: predict the item taken at this edge, then offer the next one.
    // A bound handle is filled in here, once every earlier item is predicted.
    always @(posedge clk) begin : driver
        req_s    nxt;
        result_s got;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                got = pool_step(offered);
                due_results = {due_results, got};
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (request_queue.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
                    nxt = request_queue.pop_front();
                    if (nxt.bound) begin
                        nxt.tokens = slot_owner[nxt.hslot];
                        nxt.width  = slot_width[nxt.hslot];
                        nxt.hgen   = slot_gen[nxt.hslot];
                        case (nxt.tamper)
                            TAMPER_GEN:
                                nxt.hgen = nxt.hgen ^ (32'd1 << $urandom_range(GEN_W - 1));
                            TAMPER_TOKENS:
                                nxt.tokens = nxt.tokens ^ (16'd1 << $urandom_range(TOKEN_W - 1));
                            TAMPER_WIDTH:
                                nxt.width = nxt.width ^ (13'd1 << $urandom_range(EMB_W - 1));
                            default: ;
                        endcase
                    end
                    offered           <= nxt;
                    func              <= nxt.code;
                    num_tokens        <= nxt.tokens;
                    embedding_width   <= nxt.width;
                    handle_slot       <= nxt.hslot;
                    handle_generation <= nxt.hgen;
                    in_valid          <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result item with the oldest prediction, then
    // decide whether to take a result on the next edge.
    always @(posedge clk) begin : monitor
        result_s want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    report_error($sformatf("result with nothing outstanding (status %0d)",
                                           status));
                end
                else begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_error($sformatf("status %0d, want %0d", status, want.status));
                    if (granted_slot !== want.slot)
                        report_error($sformatf("granted_slot %0d, want %0d",
                                               granted_slot, want.slot));
                    if (granted_generation !== want.gen)
                        report_error($sformatf("granted_generation %0h, want %0h",
                                               granted_generation, want.gen));
                    if (rebacked !== want.rebacked)
                        report_error($sformatf("rebacked %0b, want %0b",
                                               rebacked, want.rebacked));
                    if (free_slots !== want.free)
                        report_error($sformatf("free_slots %0d, want %0d",
                                               free_slots, want.free));
                end
            end
            out_ready <= steady || ($urandom_range(99) >= 21);
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long.
    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("best_fit_slot_pool_allocator_test NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_req(input logic [1:0] code, input logic [TOKEN_W-1:0] tokens,
                             input logic [EMB_W-1:0] width, input logic [SLOT_W-1:0] hslot,
                             input logic [GEN_W-1:0] hgen);
        req_s r;
        r.code   = code;
        r.tokens = tokens;
        r.width  = width;
        r.hslot  = hslot;
        r.hgen   = hgen;
        r.bound  = 1'b0;
        r.tamper = TAMPER_NONE;
        request_queue = {request_queue, r};
    endtask

    // Queue a release or check of whatever handle slot idx holds when offered.
    task automatic queue_handle(input logic [1:0] code, input int idx, input tamper_e how);
        req_s r;
        r = '0;
        r.code   = code;
        r.hslot  = idx[SLOT_W-1:0];
        r.bound  = 1'b1;
        r.tamper = how;
        request_queue = {request_queue, r};
    endtask

    // Mostly acquire/release/check traffic on live handles with a few widths,
    // so slots get reused, best fit gets ties and the pool fills; the rest is
    // spoiled handles and raw noise over the full field ranges.
    task automatic queue_random(input int n);
        int                 pick;
        int                 sel;
        logic [TOKEN_W-1:0] tokens;
        logic [EMB_W-1:0]   width;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 42) begin
                sel = $urandom_range(9);
                width = (sel < 4) ? 13'd64 : (sel < 6) ? 13'd3 : (sel == 6) ? 13'h1FFF :
                        (sel == 7) ? 13'd1 : EMB_W'($urandom_range(8191));
                sel = $urandom_range(99);
                tokens = (sel < 80) ? TOKEN_W'($urandom_range(1, 128)) :
                         (sel < 95) ? TOKEN_W'($urandom_range(65535)) : 16'd0;
                if ($urandom_range(99) < 3)
                    width = '0;
                queue_req(bfsp_pkg::FUNC_ACQUIRE, tokens, width, '0, '0);
            end
            else if (pick < 86) begin
                queue_handle(pick < 74 ? bfsp_pkg::FUNC_RELEASE : bfsp_pkg::FUNC_CHECK,
                             $urandom_range(SLOTS - 1),
                             ($urandom_range(99) < 80) ? TAMPER_NONE
                                                       : tamper_e'($urandom_range(1, 3)));
            end
            else begin
                queue_req(2'($urandom_range(3)), TOKEN_W'($urandom_range(65535)),
                          EMB_W'($urandom_range(8191)), SLOT_W'($urandom_range(63)),
                          ($urandom_range(9) == 0) ? 32'd0 : $urandom);
            end
        end
    endtask

    // Hold until every queued item is taken and every result has come back.
    // Sample on the falling edge so all clocked updates have settled.
    task automatic drain();
        @(negedge clk);
        while (request_queue.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
    endtask

    // Write pool_enabled while the block is idle.
    task automatic set_pool(input bit on);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        pool_on = on;
        @(negedge clk);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_backed[i] = 1'b0;
            slot_cap[i]    = '0;
            slot_width[i]  = '0;
            slot_gen[i]    = '0;
            slot_owner[i]  = '0;
            slot_busy[i]   = 1'b0;
        end

        // Directed opening, pool enabled from reset.
        // Reject acquires with zero tokens or zero width.
        queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd0, 13'd5, '0, '0);
        queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd5, 13'd0, '0, '0);
        // Back the first two empty slots, one at the largest sizes.
        queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd100, 13'd64, '0, '0);
        queue_req(bfsp_pkg::FUNC_ACQUIRE, '1, '1, '0, '0);
        // Check a good handle, then spoil each handle field in turn.
        queue_handle(bfsp_pkg::FUNC_CHECK, 0, TAMPER_NONE);
        queue_handle(bfsp_pkg::FUNC_CHECK, 0, TAMPER_GEN);
        queue_handle(bfsp_pkg::FUNC_RELEASE, 0, TAMPER_TOKENS);
        queue_handle(bfsp_pkg::FUNC_RELEASE, 1, TAMPER_WIDTH);
        // Slot index past the pool, zero generation, and the unused func.
        queue_req(bfsp_pkg::FUNC_RELEASE, 16'd100, 13'd64, '1, 32'd1);
        queue_req(bfsp_pkg::FUNC_CHECK, 16'd100, 13'd64, SLOT_W'(SLOTS), '1);
        queue_req(bfsp_pkg::FUNC_RELEASE, 16'd100, 13'd64, '0, '0);
        queue_req(FUNC_UNUSED, '1, '1, '1, '1);
        // Release, then try the now stale handle again.
        queue_handle(bfsp_pkg::FUNC_RELEASE, 0, TAMPER_NONE);
        queue_handle(bfsp_pkg::FUNC_RELEASE, 0, TAMPER_NONE);
        // Reuse a backed slot without reshaping, then force a reshape.
        queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd50, 13'd64, '0, '0);
        queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd30, 13'd64, '0, '0);
        queue_handle(bfsp_pkg::FUNC_RELEASE, 0, TAMPER_NONE);
        queue_handle(bfsp_pkg::FUNC_RELEASE, 2, TAMPER_NONE);
        // Two candidates of width 64: the smaller capacity must win.
        queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd20, 13'd64, '0, '0);
        // Fill the pool, then ask once more with every slot busy.
        repeat (SLOTS - 1) queue_req(bfsp_pkg::FUNC_ACQUIRE, 16'd1, 13'd7, '0, '0);
        queue_handle(bfsp_pkg::FUNC_RELEASE, 1, TAMPER_NONE);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Disabled backend: acquires fail, handles still work.
        set_pool(1'b0);
        queue_random(30);
        set_pool(1'b1);
        queue_random(300);
        set_pool(1'b0);
        queue_random(20);
        set_pool(1'b1);
        // Long stretch with both sides always ready, then back to random gaps.
        steady = 1'b1;
        queue_random(150);
        drain();
        steady = 1'b0;
        queue_random(130);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (due_results.size() != 0)
            report_error($sformatf("%0d results never arrived", due_results.size()));

        $display("covered %0d requests: %0d grants, %0d re-backed, %0d with pool full",
                 items_taken, n_grants, n_rebacks, n_full);
        $display("  %0d foreign handles, %0d rejected requests, %0d mismatches",
                 n_not_owner, n_rejected, failures);
        if (failures == 0)
            $display("best_fit_slot_pool_allocator_test OK");
        else
            $display("best_fit_slot_pool_allocator_test NOT OK");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_cell.sv
hw/rtl/best_fit_slot_pool_allocator.sv
test/best_fit_slot_pool_allocator_test.sv
